### rtl/ctc_pkg.sv
// Shared types and constants for the cruise throttle controller.
// No dependencies; imported by ctc_update and the top level.
`default_nettype none

package ctc_pkg;

  localparam int unsigned StepW  = 7;
  localparam int unsigned MaxW   = 8;
  localparam int unsigned MinVW  = 10;
  localparam int unsigned VelW   = 11;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned InW    = 16;
  localparam int unsigned OutW   = 32;

  localparam logic [1:0] BTN_NONE   = 2'd0;
  localparam logic [1:0] BTN_GAS    = 2'd1;
  localparam logic [1:0] BTN_BRAKE  = 2'd2;
  localparam logic [1:0] BTN_CRUISE = 2'd3;

  localparam logic [IdxW-1:0] REG_STEP    = 2'd0;
  localparam logic [IdxW-1:0] REG_MAX     = 2'd1;
  localparam logic [IdxW-1:0] REG_MIN_VEL = 2'd2;

  localparam logic [StepW-1:0] STEP_RST    = 7'd20;
  localparam logic [MaxW-1:0]  MAX_RST     = 8'd80;
  localparam logic [MinVW-1:0] MIN_VEL_RST = 10'd200;

  typedef struct packed {
    logic [StepW-1:0] step;
    logic [MaxW-1:0]  tmax;
    logic [MinVW-1:0] min_vel;
  } cfg_t;

  typedef struct packed {
    logic                   gas;
    logic                   brake;
    logic                   cruise;
    logic                   engine;
    logic                   gear;
    logic [MaxW-1:0]        throttle;
    logic signed [VelW-1:0] prev_vel;
    logic signed [VelW-1:0] target;
    logic                   armed;
  } state_t;

  typedef struct packed {
    logic [1:0]             button;
    logic                   engine_switch;
    logic                   gear_switch;
    logic signed [VelW-1:0] velocity;
  } tick_t;

endpackage

`default_nettype wire

### rtl/ctc_update.sv
// Per-tick next-state logic: button rules, switch rules, cruise regulation, gas.
// Depends on ctc_pkg.
`default_nettype none

module ctc_update (
  input  ctc_pkg::state_t st,
  input  ctc_pkg::cfg_t   cfg,
  input  ctc_pkg::tick_t  tick,
  output ctc_pkg::state_t st_next,
  output logic            regulating
);
  import ctc_pkg::*;

  state_t                 n;
  logic signed [VelW:0]   prev_ext;
  logic signed [VelW:0]   min_ext;
  logic signed [VelW-1:0] tgt;
  logic [MaxW:0]          rise_sum;
  logic [MaxW-1:0]        thr_reg;
  logic [MaxW:0]          gas_sum;
  logic [MaxW-1:0]        thr_gas;
  logic                   reg_cond;

  always_comb begin
    n = st;

    case (tick.button)
      BTN_GAS: begin
        if (st.engine) begin
          n.gas = 1'b1; n.brake = 1'b0; n.cruise = 1'b0;
        end
      end
      BTN_BRAKE: begin
        n.gas = 1'b0; n.brake = 1'b1; n.cruise = 1'b0;
      end
      BTN_CRUISE: begin
        if (st.engine && st.gear) begin
          n.gas = 1'b0; n.brake = 1'b0; n.cruise = 1'b1;
        end
      end
      default: begin
        n.gas = 1'b0; n.brake = 1'b0; n.cruise = 1'b0;
      end
    endcase

    case ({tick.engine_switch, tick.gear_switch})
      2'b10: begin
        n.engine = 1'b1; n.gear = 1'b0; n.cruise = 1'b0;
      end
      2'b01: begin
        n.gear = 1'b1;
        if (tick.velocity == '0) begin
          n.engine = 1'b0; n.gas = 1'b0; n.cruise = 1'b0;
        end
      end
      2'b11: begin
        n.engine = 1'b1; n.gear = 1'b1;
      end
      default: begin
        n.engine = 1'b0; n.gear = 1'b0; n.cruise = 1'b0;
      end
    endcase

    prev_ext = {st.prev_vel[VelW-1], st.prev_vel};
    min_ext  = $signed({2'b00, cfg.min_vel});
    reg_cond = n.engine && n.cruise && (prev_ext >= min_ext);
    tgt      = st.armed ? st.prev_vel : st.target;

    rise_sum = {1'b0, st.throttle} + {2'b00, cfg.step};
    thr_reg  = st.throttle;
    if (reg_cond) begin
      if (tick.velocity > tgt) begin
        thr_reg = (st.throttle >= {1'b0, cfg.step}) ?
                  st.throttle - {1'b0, cfg.step} : '0;
      end else if (tick.velocity < tgt) begin
        thr_reg = (rise_sum <= {1'b0, cfg.tmax}) ? rise_sum[MaxW-1:0] : cfg.tmax;
      end
    end

    gas_sum = {1'b0, thr_reg} + {2'b00, cfg.step};
    thr_gas = thr_reg;
    if (n.gas && (thr_reg <= cfg.tmax)) begin
      thr_gas = (gas_sum > {1'b0, cfg.tmax}) ? cfg.tmax : gas_sum[MaxW-1:0];
    end

    if (n.engine) begin
      if (reg_cond) begin
        n.target = tgt;
        n.armed  = 1'b0;
      end else begin
        n.armed  = 1'b1;
      end
      n.prev_vel = tick.velocity;
      n.throttle = thr_gas;
    end

    st_next    = n;
    regulating = reg_cond;
  end

endmodule

`default_nettype wire

### rtl/cruise_throttle_controller_unit.sv
// Cruise throttle controller top level: stream ports, tick register, state and result register.
// Depends on ctc_pkg and ctc_update.
//
// Usage: each beat on the s_ side is one control tick. It is held in an input
// register, then the combinational next-state logic in ctc_update runs and the
// result beat is loaded into the m_ side register together with the new state.
// Throughput: one tick per cycle while m_tready does not stall the result beat.
// Config: cfg_valid/cfg_index/cfg_data write throttle_step (0), throttle_max (1)
// and cruise_min_velocity (2); cfg_ready is always high. Write only while idle.
// Reset (rst, synchronous): modes off, throttle, previous velocity and target
// zero, target latch armed, registers to defaults, both stages empty.
// Stall: when m_tready is low the result beat holds; the input stage holds one
// more tick and s_tready drops once both stages are full.
`default_nettype none

module cruise_throttle_controller_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [1:0] button, [2] engine_switch, [3] gear_switch, [14:4] velocity, [15] zero
  input  logic [ctc_pkg::InW-1:0]      s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [7:0] throttle_out, [8] regulating, [9] gas_active, [10] brake_active,
  // [11] cruise_active, [12] engine_active, [13] gear_active,
  // [24:14] target_velocity, [31:25] zero
  output logic [ctc_pkg::OutW-1:0]     m_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ctc_pkg::IdxW-1:0]     cfg_index,
  input  logic [ctc_pkg::MinVW-1:0]    cfg_data
);
  import ctc_pkg::*;

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  tick_t  tick;
  logic   in_valid;
  logic   regulating;
  logic   out_load;
  logic   advance;

  assign cfg_ready = 1'b1;
  assign out_load  = !m_tvalid || m_tready;
  assign advance   = in_valid && out_load;
  assign s_tready  = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step    <= STEP_RST;
      cfg.tmax    <= MAX_RST;
      cfg.min_vel <= MIN_VEL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEP:    cfg.step    <= cfg_data[StepW-1:0];
        REG_MAX:     cfg.tmax    <= cfg_data[MaxW-1:0];
        REG_MIN_VEL: cfg.min_vel <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      tick.button        <= s_tdata[1:0];
      tick.engine_switch <= s_tdata[2];
      tick.gear_switch   <= s_tdata[3];
      tick.velocity      <= s_tdata[VelW+3:4];
    end
  end

  ctc_update u_update (
    .st         (st),
    .cfg        (cfg),
    .tick       (tick),
    .st_next    (st_next),
    .regulating (regulating)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{gas: 1'b0, brake: 1'b0, cruise: 1'b0, engine: 1'b0, gear: 1'b0,
              throttle: '0, prev_vel: '0, target: '0, armed: 1'b1};
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {7'd0, st_next.target, st_next.gear, st_next.engine, st_next.cruise,
                  st_next.brake, st_next.gas, regulating, st_next.throttle};
    end
  end

endmodule

`default_nettype wire

### rtl/ctc_checker.sv
// Port-level checks for the cruise throttle controller, bound to the top level.
// Depends on ctc_pkg and cruise_throttle_controller_unit.
`default_nettype none

module ctc_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [ctc_pkg::OutW-1:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  a_pedal_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[11:9]))
    else $error("gas, brake and cruise not exclusive");

  a_cruise_modes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[11] |-> m_tdata[12] && m_tdata[13])
    else $error("cruise active without engine and top gear");

  a_reg_cruise: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[11])
    else $error("regulating without cruise active");

endmodule

bind cruise_throttle_controller_unit ctc_checker u_ctc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

### bench/tb_top.sv
// Testbench for cruise_throttle_controller_unit: a directed table of ticks, then random
// driving sequences over several register settings, checked against typed rows or a model.
// Depends on ctc_pkg and the RTL of the unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ctc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_TICKS = 66;

  typedef struct packed {
    logic [MaxW-1:0]        throttle;
    logic                   regulating;
    logic                   gas;
    logic                   brake;
    logic                   cruise;
    logic                   engine;
    logic                   gear;
    logic signed [VelW-1:0] target;
  } ctrl_result_t;

  typedef struct packed {
    tick_t        tick;
    logic         typed;
    ctrl_result_t want;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [InW-1:0]    s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [OutW-1:0]   m_tdata;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IdxW-1:0]   cfg_index;
  logic [MinVW-1:0]  cfg_data;

  // controller model: settings and state
  logic [StepW-1:0]       set_step;
  logic [MaxW-1:0]        set_max;
  logic [MinVW-1:0]       set_min_vel;
  logic                   gas_on, brake_on, cruise_on, engine_on, gear_on;
  logic [MaxW-1:0]        throttle_now;
  logic signed [VelW-1:0] last_velocity;
  logic signed [VelW-1:0] held_target;
  logic                   latch_armed;

  ctrl_result_t pending_results[$];
  int           mismatch_count = 0;
  int           checked_count  = 0;
  int           cruise_base    = 200;
  bit           long_hold_req  = 1'b0;
  bit           quiet_tail     = 1'b0;

  int unsigned phase_step[NUM_PHASES] = '{20, 80, 0, 80, 1, 37, 0, 0};
  int unsigned phase_max [NUM_PHASES] = '{80, 60, 255, 255, 10, 0, 0, 0};
  int unsigned phase_minv[NUM_PHASES] = '{200, 0, 1023, 0, 500, 300, 0, 0};

  cruise_throttle_controller_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void reset_controller_model();
    set_step      = STEP_RST;
    set_max       = MAX_RST;
    set_min_vel   = MIN_VEL_RST;
    gas_on        = 1'b0;
    brake_on      = 1'b0;
    cruise_on     = 1'b0;
    engine_on     = 1'b0;
    gear_on       = 1'b0;
    throttle_now  = '0;
    last_velocity = '0;
    held_target   = '0;
    latch_armed   = 1'b1;
  endfunction

  function automatic void predict_tick(input tick_t t, output ctrl_result_t r);
    int thr;
    int step;
    int tmax;
    bit reg_now;
    thr     = int'(throttle_now);
    step    = int'(set_step);
    tmax    = int'(set_max);
    reg_now = 1'b0;

    case (t.button)
      BTN_GAS: begin
        if (engine_on) begin
          gas_on = 1'b1; brake_on = 1'b0; cruise_on = 1'b0;
        end
      end
      BTN_BRAKE: begin
        gas_on = 1'b0; brake_on = 1'b1; cruise_on = 1'b0;
      end
      BTN_CRUISE: begin
        if (gear_on && engine_on) begin
          gas_on = 1'b0; brake_on = 1'b0; cruise_on = 1'b1;
        end
      end
      default: begin
        gas_on = 1'b0; brake_on = 1'b0; cruise_on = 1'b0;
      end
    endcase

    if (t.engine_switch && !t.gear_switch) begin
      engine_on = 1'b1; gear_on = 1'b0; cruise_on = 1'b0;
    end else if (!t.engine_switch && t.gear_switch) begin
      gear_on = 1'b1;
      if (t.velocity == 0) begin
        engine_on = 1'b0; gas_on = 1'b0; cruise_on = 1'b0;
      end
    end else if (t.engine_switch && t.gear_switch) begin
      engine_on = 1'b1; gear_on = 1'b1;
    end else begin
      engine_on = 1'b0; gear_on = 1'b0; cruise_on = 1'b0;
    end

    if (engine_on) begin
      if (cruise_on && int'(last_velocity) >= int'(set_min_vel)) begin
        reg_now = 1'b1;
        if (latch_armed) begin
          held_target = last_velocity;
          latch_armed = 1'b0;
        end
        if (t.velocity > held_target) begin
          thr = (thr >= step) ? thr - step : 0;
        end else if (t.velocity < held_target) begin
          thr = (thr <= tmax - step) ? thr + step : tmax;
        end
      end else begin
        latch_armed = 1'b1;
      end
      last_velocity = t.velocity;
      if (gas_on && thr <= tmax) begin
        thr = thr + step;
        if (thr > tmax) thr = tmax;
      end
      throttle_now = 8'(thr);
    end

    r.throttle   = throttle_now;
    r.regulating = reg_now;
    r.gas        = gas_on;
    r.brake      = brake_on;
    r.cruise     = cruise_on;
    r.engine     = engine_on;
    r.gear       = gear_on;
    r.target     = held_target;
  endfunction

  function automatic dir_row_t row(input logic [1:0] b, input bit e, input bit g, input int v,
                                   input bit typed, input int thr, input bit gas,
                                   input bit brk, input bit eng, input bit gr);
    dir_row_t d;
    d.tick.button        = b;
    d.tick.engine_switch = e;
    d.tick.gear_switch   = g;
    d.tick.velocity      = 11'(v);
    d.typed              = typed;
    d.want               = '{8'(thr), 1'b0, gas, brk, 1'b0, eng, gr, 11'sd0};
    return d;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int    pick;
    int    v;
    pick            = $urandom_range(0, 99);
    t.button        = 2'($urandom);
    t.engine_switch = 1'($urandom);
    t.gear_switch   = 1'($urandom);
    v               = int'($urandom_range(0, 2047)) - 1024;
    if (pick < 70) begin
      // engine running, mostly holding cruise around a set speed
      t.engine_switch = 1'b1;
      t.gear_switch   = ($urandom_range(0, 19) != 0);
      case ($urandom_range(0, 9))
        0:       t.button = BTN_NONE;
        1:       t.button = BTN_GAS;
        2:       t.button = BTN_BRAKE;
        default: t.button = BTN_CRUISE;
      endcase
      v = cruise_base + int'($urandom_range(0, 40)) - 20;
    end else if (pick < 85) begin
      v = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 60)) - 30;
    end
    if (v > 1023) v = 1023;
    if (v < -1024) v = -1024;
    t.velocity = 11'(v);
    return t;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatch_count++;
    $display("tick %0d: %s got %0d, expected %0d", checked_count, field, got, want);
  endtask

  task automatic send_tick(input tick_t t, input bit typed, input ctrl_result_t want);
    ctrl_result_t r;
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, t.velocity, t.gear_switch, t.engine_switch, t.button};
    do @(posedge clk); while (!s_tready);
    predict_tick(t, r);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic sender_gap();
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [IdxW-1:0] idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= MinVW'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STEP:    set_step    = StepW'(value);
      REG_MAX:     set_max     = MaxW'(value);
      REG_MIN_VEL: set_min_vel = MinVW'(value);
      default: ;
    endcase
  endtask

  task automatic load_settings(input int unsigned step, input int unsigned tmax,
                               input int unsigned minv);
    settle_idle();
    put_reg(REG_STEP, step);
    put_reg(REG_MAX, tmax);
    put_reg(REG_MIN_VEL, minv);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls, one long hold on request, none in the tail
  initial begin : result_sink
    int n;
    m_tready = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        n = 60;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 7);
      end else begin
        m_tready <= 1'b1;
        n = $urandom_range(1, 10);
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    ctrl_result_t got;
    ctrl_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[7:0], m_tdata[8], m_tdata[9], m_tdata[10], m_tdata[11],
              m_tdata[12], m_tdata[13], m_tdata[24:14]};
      if (pending_results.size() == 0) begin
        report_mismatch("unrequested result beat", int'(m_tdata), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.throttle !== want.throttle)
          report_mismatch("throttle_out", got.throttle, want.throttle);
        if (got.regulating !== want.regulating)
          report_mismatch("regulating", got.regulating, want.regulating);
        if (got.gas !== want.gas) report_mismatch("gas_active", got.gas, want.gas);
        if (got.brake !== want.brake) report_mismatch("brake_active", got.brake, want.brake);
        if (got.cruise !== want.cruise)
          report_mismatch("cruise_active", got.cruise, want.cruise);
        if (got.engine !== want.engine)
          report_mismatch("engine_active", got.engine, want.engine);
        if (got.gear !== want.gear) report_mismatch("gear_active", got.gear, want.gear);
        if (got.target !== want.target)
          report_mismatch("target_velocity", int'(got.target), int'(want.target));
      end
      checked_count++;
    end
  end

  initial begin : stall_watch
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("cruise_throttle_controller_unit test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    dir_row_t     directed_rows[$];
    ctrl_result_t none;
    int unsigned  st;
    int unsigned  mx;
    int unsigned  mv;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    none      = '0;
    reset_controller_model();

    // defaults: step 20, max 80, min velocity 200
    directed_rows.push_back(row(BTN_NONE,   0, 0, 0,     1, 0,  0, 0, 0, 0));
    directed_rows.push_back(row(BTN_GAS,    1, 0, 0,     1, 0,  0, 0, 1, 0));
    directed_rows.push_back(row(BTN_GAS,    1, 0, 100,   1, 20, 1, 0, 1, 0));
    directed_rows.push_back(row(BTN_GAS,    1, 0, 100,   1, 40, 1, 0, 1, 0));
    directed_rows.push_back(row(BTN_GAS,    1, 0, 100,   1, 60, 1, 0, 1, 0));
    directed_rows.push_back(row(BTN_GAS,    1, 0, 100,   1, 80, 1, 0, 1, 0));
    directed_rows.push_back(row(BTN_GAS,    1, 0, 100,   1, 80, 1, 0, 1, 0));
    directed_rows.push_back(row(BTN_BRAKE,  1, 1, 100,   1, 80, 0, 1, 1, 1));
    directed_rows.push_back(row(BTN_CRUISE, 1, 1, 300,   0, 0,  0, 0, 0, 0));
    directed_rows.push_back(row(BTN_CRUISE, 1, 1, 250,   0, 0,  0, 0, 0, 0));
    directed_rows.push_back(row(BTN_CRUISE, 1, 1, 400,   0, 0,  0, 0, 0, 0));
    directed_rows.push_back(row(BTN_CRUISE, 1, 1, 300,   0, 0,  0, 0, 0, 0));
    directed_rows.push_back(row(BTN_CRUISE, 1, 1, -1024, 0, 0,  0, 0, 0, 0));
    directed_rows.push_back(row(BTN_CRUISE, 1, 1, 1023,  0, 0,  0, 0, 0, 0));
    directed_rows.push_back(row(BTN_CRUISE, 1, 1, 1023,  0, 0,  0, 0, 0, 0));
    directed_rows.push_back(row(BTN_CRUISE, 1, 0, 500,   0, 0,  0, 0, 0, 0));
    directed_rows.push_back(row(BTN_GAS,    1, 1, 500,   0, 0,  0, 0, 0, 0));
    directed_rows.push_back(row(BTN_NONE,   0, 1, 500,   0, 0,  0, 0, 0, 0));
    directed_rows.push_back(row(BTN_NONE,   0, 1, 0,     0, 0,  0, 0, 0, 0));
    directed_rows.push_back(row(BTN_GAS,    0, 0, -1,    0, 0,  0, 0, 0, 0));
    directed_rows.push_back(row(BTN_CRUISE, 0, 0, 1023,  0, 0,  0, 0, 0, 0));
    directed_rows.push_back(row(BTN_BRAKE,  1, 1, -1024, 0, 0,  0, 0, 0, 0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      sender_gap();
      send_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      st = phase_step[p];
      mx = phase_max[p];
      mv = phase_minv[p];
      if (p >= 6) begin
        st = $urandom_range(0, 80);
        mx = $urandom_range(0, 255);
        mv = $urandom_range(0, 1023);
      end
      load_settings(st, mx, mv);
      if (p == NUM_PHASES - 1) quiet_tail = 1'b1;
      for (int k = 0; k < PHASE_TICKS; k++) begin
        if (k % 15 == 0)
          cruise_base = int'(set_min_vel) - 20 + int'($urandom_range(0, 80));
        if (p == 1 && k == 10) long_hold_req = 1'b1;
        sender_gap();
        send_tick(random_tick(), 1'b0, none);
      end
    end

    settle_idle();
    if (mismatch_count == 0) begin
      $display("cruise_throttle_controller_unit test passed");
    end else begin
      $display("cruise_throttle_controller_unit test failed");
    end
    $finish;
  end

endmodule
